// File: rtl/serial_midi_to_usb_midi_packet_assert.svh
// assertion macros for the serial midi to usb midi packet block
`ifndef SERIAL_MIDI_TO_USB_MIDI_PACKET_ASSERT_SVH
`define SERIAL_MIDI_TO_USB_MIDI_PACKET_ASSERT_SVH

// condition holds in the same cycle
`define SMU_ASSERT_NOW(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// antecedent implies consequent in the same cycle
`define SMU_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define SMU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/smu_pkg.sv
// shared types, constants and the phase table of the midi packet converter
package smu_pkg;

    localparam logic [7:0] SysexStart  = 8'hF0;
    localparam logic [7:0] CommonMin   = 8'hF1;
    localparam logic [7:0] SysexEnd    = 8'hF7;
    localparam logic [7:0] RealtimeMin = 8'hF8;
    localparam logic [3:0] CinRealtime = 4'hF;
    localparam logic [3:0] PhaseIdle   = 4'd0;
    localparam int         StatusBit   = 7;
    localparam int         CompleteBit = 7;

    typedef struct packed {
        logic [3:0] code_index;
        logic [7:0] status_byte;
        logic [6:0] first_data;
        logic [6:0] second_data;
    } smu_packet_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] rx_byte;
    } smu_stage_t;

    typedef struct packed {
        logic        hit;
        smu_packet_t pkt;
    } smu_result_t;

    // next phase in low nibble, top bit flags a complete message
    function automatic logic [7:0] next_phase(input logic [3:0] phase);
        logic [7:0] t;
        case (phase)
            4'd2:    t = 8'h03;
            4'd3:    t = 8'h82;
            4'd4:    t = 8'h05;
            4'd5:    t = 8'h84;
            4'd6:    t = 8'h07;
            4'd7:    t = 8'h86;
            4'd8:    t = 8'h09;
            4'd9:    t = 8'h88;
            4'd10:   t = 8'h8A;
            4'd12:   t = 8'h8C;
            4'd14:   t = 8'h0F;
            4'd15:   t = 8'h8E;
            default: t = 8'h00;
        endcase
        return t;
    endfunction

endpackage

// File: rtl/smu_in_if.sv
// channel carrying one serial midi byte per word
interface smu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// File: rtl/smu_out_if.sv
// channel carrying one usb midi event packet per word
interface smu_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] code_index;
    logic [7:0] status_byte;
    logic [6:0] first_data;
    logic [6:0] second_data;

    modport source (output valid, output code_index, output status_byte,
                    output first_data, output second_data, input ready);
    modport sink   (input valid, input code_index, input status_byte,
                    input first_data, input second_data, output ready);
endinterface

// File: rtl/smu_in_stage.sv
// input register holding one received byte
module smu_in_stage
    import smu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    smu_in_if.sink      serial,
    input  logic        advance,
    output smu_stage_t  stage
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       load;

    assign serial.ready = !valid_reg || advance;
    assign load         = serial.valid && serial.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= serial.rx_byte;
        end
    end

    assign stage.valid   = valid_reg;
    assign stage.rx_byte = byte_reg;

endmodule

// File: rtl/smu_parser.sv
// midi message state and packet assembly
module smu_parser
    import smu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  rx_byte,
    input  logic        advance,
    output smu_result_t result
);

    logic       sysex_reg;
    logic       sysex_next;
    logic [3:0] phase_reg;
    logic [3:0] phase_next;
    logic [7:0] status_reg;
    logic [7:0] status_next;
    logic [6:0] first_reg;
    logic [6:0] first_next;
    logic [6:0] second_reg;
    logic [6:0] second_next;
    logic [7:0] t;

    assign t = next_phase(phase_reg);

    always_comb
    begin
        sysex_next  = sysex_reg;
        phase_next  = phase_reg;
        status_next = status_reg;
        first_next  = first_reg;
        second_next = second_reg;
        result      = '0;
        if (sysex_reg)
        begin
            if (rx_byte == SysexEnd)
            begin
                sysex_next = 1'b0;
            end
        end
        else if (rx_byte >= RealtimeMin)
        begin
            result.hit             = 1'b1;
            result.pkt.code_index  = CinRealtime;
            result.pkt.status_byte = rx_byte;
        end
        else if (rx_byte[StatusBit])
        begin
            if (rx_byte == SysexStart)
            begin
                sysex_next = 1'b1;
            end
            else if (rx_byte >= CommonMin)
            begin
                phase_next = PhaseIdle;
            end
            else
            begin
                phase_next  = {3'(rx_byte[6:4] + 3'd1), 1'b0};
                status_next = rx_byte;
                first_next  = '0;
                second_next = '0;
            end
        end
        else if (phase_reg != PhaseIdle)
        begin
            if (phase_reg[0])
            begin
                second_next = rx_byte[6:0];
            end
            else
            begin
                first_next = rx_byte[6:0];
            end
            phase_next = t[3:0];
            if (t[CompleteBit])
            begin
                result.hit             = 1'b1;
                result.pkt.code_index  = status_reg[7:4];
                result.pkt.status_byte = status_reg;
                result.pkt.first_data  = first_next;
                result.pkt.second_data = second_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sysex_reg  <= 1'b0;
            phase_reg  <= PhaseIdle;
            status_reg <= '0;
            first_reg  <= '0;
            second_reg <= '0;
        end
        else if (advance)
        begin
            sysex_reg  <= sysex_next;
            phase_reg  <= phase_next;
            status_reg <= status_next;
            first_reg  <= first_next;
            second_reg <= second_next;
        end
    end

endmodule

// File: rtl/smu_out_stage.sv
// output register holding one finished packet
module smu_out_stage
    import smu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  smu_result_t result,
    input  logic        load,
    output logic        free,
    smu_out_if.source   usb
);

    logic        valid_reg;
    logic        valid_next;
    smu_packet_t pkt_reg;

    assign free = !valid_reg || usb.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (usb.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            pkt_reg <= result.pkt;
        end
    end

    assign usb.valid       = valid_reg;
    assign usb.code_index  = pkt_reg.code_index;
    assign usb.status_byte = pkt_reg.status_byte;
    assign usb.first_data  = pkt_reg.first_data;
    assign usb.second_data = pkt_reg.second_data;

endmodule

// File: rtl/serial_midi_to_usb_midi_packet.sv
// top level of the serial midi to usb midi event packet converter
//
// serial: one received midi byte per word (rx_byte)
// usb:    one usb midi event packet per word, cable 0
//         (code_index, status_byte, first_data, second_data)
// a byte that completes a channel message, or any realtime byte outside sysex,
// gives one packet; every other byte gives none
// an accepted byte goes into the input register, then is parsed into
// the output register, which presents its packet at the usb port
// throughput: one byte per cycle while the output register is free;
// the parser updates its message state once per byte
// reset marks both registers empty and clears the message state: no status held,
// not inside sysex
// when the usb side stalls, the output register holds its packet and
// one more byte waits in the input register; serial ready then drops
// until the packet is taken
`include "serial_midi_to_usb_midi_packet_assert.svh"

module serial_midi_to_usb_midi_packet
    import smu_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    smu_in_if.sink    serial,
    smu_out_if.source usb
);

    smu_stage_t  stage;
    smu_result_t result;
    logic        free;
    logic        advance;
    logic        load;

    assign advance = stage.valid && free;
    assign load    = advance && result.hit;

    smu_in_stage u_in_stage (
        .clk     (clk),
        .rst_n   (rst_n),
        .serial  (serial),
        .advance (advance),
        .stage   (stage)
    );

    smu_parser u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .rx_byte (stage.rx_byte),
        .advance (advance),
        .result  (result)
    );

    smu_out_stage u_out_stage (
        .clk    (clk),
        .rst_n  (rst_n),
        .result (result),
        .load   (load),
        .free   (free),
        .usb    (usb)
    );

    // held byte stays put while the output side is full
    `SMU_ASSERT_NEXT(a_stall_hold, clk, rst_n, stage.valid && !free,
        stage.valid && $stable(stage.rx_byte), "held byte lost during stall")

    // a loaded packet appears at the usb port next cycle
    `SMU_ASSERT_NEXT(a_load_shows, clk, rst_n, load, usb.valid,
        "loaded packet not presented")

    // realtime packets carry a realtime status
    `SMU_ASSERT_IMPLIES(a_realtime, clk, rst_n,
        usb.valid && usb.code_index == CinRealtime, usb.status_byte >= RealtimeMin,
        "realtime code with non-realtime status")

    // channel packets carry the status high nibble
    `SMU_ASSERT_IMPLIES(a_channel, clk, rst_n,
        usb.valid && usb.code_index != CinRealtime,
        usb.status_byte[7] && usb.code_index == usb.status_byte[7:4]
            && usb.status_byte < SysexStart,
        "channel packet code does not match status")

endmodule
